/* sv/mplm_pkg.sv */
// mplm_pkg: shared types and constants of the motor phase loss monitor
// depends on nothing; used by every module under sv/
`timescale 1ns / 1ps
`default_nettype none

package mplm_pkg;

  // field widths
  localparam int unsigned VOLT_W  = 18;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned TORQ_W  = 20;
  localparam int unsigned THR_T_W = 19;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned SUM_W   = 34;
  localparam int unsigned CNT_W   = 16;

  // configuration bus
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (word address)
  typedef enum logic [2:0] {
    REG_MIN_VOLTAGE      = 3'd0,
    REG_LOW_SPEED_LIMIT  = 3'd1,
    REG_ROTATING_SPEED   = 3'd2,
    REG_TORQUE_THRESHOLD = 3'd3,
    REG_CURRENT_SQ_THR   = 3'd4,
    REG_LOSS_DURATION    = 3'd5
  } reg_idx_t;

  // reset values of the registers
  localparam logic [VOLT_W-1:0]  RST_MIN_VOLTAGE      = 18'd172;
  localparam logic [SPEED_W-1:0] RST_LOW_SPEED_LIMIT  = 24'd25600;
  localparam logic [SPEED_W-1:0] RST_ROTATING_SPEED   = 24'd10723;
  localparam logic [THR_T_W-1:0] RST_TORQUE_THRESHOLD = 19'd17;
  localparam logic [SQ_W-1:0]    RST_CURRENT_SQ_THR   = 32'd207;
  localparam logic [CNT_W-1:0]   RST_LOSS_DURATION    = 16'd100;

  // live register values
  typedef struct packed {
    logic [VOLT_W-1:0]  min_voltage;
    logic [SPEED_W-1:0] low_speed_limit;
    logic [SPEED_W-1:0] rotating_speed;
    logic [THR_T_W-1:0] torque_threshold;
    logic [SQ_W-1:0]    current_sq_threshold;
    logic [CNT_W-1:0]   loss_duration;
  } cfg_t;

  // per counter update control
  typedef struct packed {
    logic upd;        // counter changes this tick
    logic up;         // count up, else down or clear
    logic clr_down;   // a non-up tick clears instead of decrementing
  } cnt_ctrl_t;

endpackage

`default_nettype wire

/* sv/motor_phase_loss_monitor.sv */
// motor_phase_loss_monitor: top level, input register, counters, result register
// depends on mplm_pkg, mplm_cfg_regs, mplm_cond, mplm_loss_cnt
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    voltage, speed, torque, three squares
//   out_     result     out_valid / out_ready  error flag and four trip bits
//   cfg      APB write  psel/penable/pwrite    six threshold registers, pready tied high
//
// one tick per clock sustained while out_ready holds; from accept to out_valid a tick passes
// (input register, then compares and counter update into the result register)
// the counter update path takes one count step per tick, in order
// reset is synchronous: counters, sticky error and valid flags clear, registers reload
// a stalled result holds the result register; the input register still takes one more tick
`timescale 1ns / 1ps
`default_nettype none

module motor_phase_loss_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [mplm_pkg::VOLT_W-1:0]        in_voltage_amplitude,
  input  wire logic [mplm_pkg::SPEED_W-1:0]       in_speed_abs,
  input  wire logic signed [mplm_pkg::TORQ_W-1:0] in_torque_command,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_u,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_v,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_w,
  // result channel
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_error_flag,
  output      logic                               out_sum_trip,
  output      logic                               out_u_trip,
  output      logic                               out_v_trip,
  output      logic                               out_w_trip,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mplm_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [mplm_pkg::DATA_W-1:0]        pwdata,
  output      logic [mplm_pkg::DATA_W-1:0]        prdata,
  output      logic                               pready
);

  mplm_pkg::cfg_t      cfg;
  mplm_pkg::cnt_ctrl_t sum_ctrl;
  mplm_pkg::cnt_ctrl_t u_ctrl;
  mplm_pkg::cnt_ctrl_t v_ctrl;
  mplm_pkg::cnt_ctrl_t w_ctrl;

  logic                               in_acc;
  logic                               s1_adv;
  logic                               s1_valid_r;
  logic [mplm_pkg::VOLT_W-1:0]        volt_r;
  logic [mplm_pkg::SPEED_W-1:0]       speed_r;
  logic signed [mplm_pkg::TORQ_W-1:0] torque_r;
  logic [mplm_pkg::SQ_W-1:0]          sq_u_r;
  logic [mplm_pkg::SQ_W-1:0]          sq_v_r;
  logic [mplm_pkg::SQ_W-1:0]          sq_w_r;

  logic sum_trip;
  logic u_trip;
  logic v_trip;
  logic w_trip;
  logic any_trip;
  logic sticky_r;
  logic sticky_nxt;

  logic out_valid_r;
  logic err_r;
  logic sum_trip_r;
  logic u_trip_r;
  logic v_trip_r;
  logic w_trip_r;

  // configuration registers
  mplm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      volt_r   <= in_voltage_amplitude;
      speed_r  <= in_speed_abs;
      torque_r <= in_torque_command;
      sq_u_r   <= in_square_u;
      sq_v_r   <= in_square_v;
      sq_w_r   <= in_square_w;
    end
  end

  // threshold compares
  mplm_cond u_cond (
    .cfg               (cfg),
    .voltage_amplitude (volt_r),
    .speed_abs         (speed_r),
    .torque_command    (torque_r),
    .square_u          (sq_u_r),
    .square_v          (sq_v_r),
    .square_w          (sq_w_r),
    .sum_ctrl          (sum_ctrl),
    .u_ctrl            (u_ctrl),
    .v_ctrl            (v_ctrl),
    .w_ctrl            (w_ctrl)
  );

  // loss counters
  mplm_loss_cnt u_sum_cnt (
    .clk (clk), .rst_n (rst_n), .adv (s1_adv), .ctrl (sum_ctrl),
    .duration (cfg.loss_duration), .trip (sum_trip)
  );
  mplm_loss_cnt u_u_cnt (
    .clk (clk), .rst_n (rst_n), .adv (s1_adv), .ctrl (u_ctrl),
    .duration (cfg.loss_duration), .trip (u_trip)
  );
  mplm_loss_cnt u_v_cnt (
    .clk (clk), .rst_n (rst_n), .adv (s1_adv), .ctrl (v_ctrl),
    .duration (cfg.loss_duration), .trip (v_trip)
  );
  mplm_loss_cnt u_w_cnt (
    .clk (clk), .rst_n (rst_n), .adv (s1_adv), .ctrl (w_ctrl),
    .duration (cfg.loss_duration), .trip (w_trip)
  );

  // sticky error
  assign any_trip   = sum_trip || u_trip || v_trip || w_trip;
  assign sticky_nxt = sticky_r || any_trip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sticky_r <= 1'b0;
    end else if (s1_adv) begin
      sticky_r <= sticky_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      err_r      <= sticky_nxt;
      sum_trip_r <= sum_trip;
      u_trip_r   <= u_trip;
      v_trip_r   <= v_trip;
      w_trip_r   <= w_trip;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_error_flag = err_r;
  assign out_sum_trip   = sum_trip_r;
  assign out_u_trip     = u_trip_r;
  assign out_v_trip     = v_trip_r;
  assign out_w_trip     = w_trip_r;

`ifndef SYNTHESIS
  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |=> sticky_r)
    else $error("sticky error dropped without reset");

  a_trip_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (sum_trip_r || u_trip_r || v_trip_r || w_trip_r)) |-> err_r)
    else $error("trip reported without error flag");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced tick lost before result register");

  a_stall_blocks_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !s1_adv)
    else $error("stage advanced into a stalled result register");
`endif

endmodule

`default_nettype wire

/* sv/mplm_cfg_regs.sv */
// mplm_cfg_regs: APB-style register file for the monitor thresholds
// depends on mplm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mplm_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mplm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mplm_pkg::DATA_W-1:0] pwdata,
  output      logic [mplm_pkg::DATA_W-1:0] prdata,
  output      logic                        pready,
  output      mplm_pkg::cfg_t              cfg
);

  mplm_pkg::cfg_t cfg_r;
  mplm_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        mplm_pkg::REG_MIN_VOLTAGE:      cfg_nxt.min_voltage = pwdata[mplm_pkg::VOLT_W-1:0];
        mplm_pkg::REG_LOW_SPEED_LIMIT:  cfg_nxt.low_speed_limit =
                                          pwdata[mplm_pkg::SPEED_W-1:0];
        mplm_pkg::REG_ROTATING_SPEED:   cfg_nxt.rotating_speed =
                                          pwdata[mplm_pkg::SPEED_W-1:0];
        mplm_pkg::REG_TORQUE_THRESHOLD: cfg_nxt.torque_threshold =
                                          pwdata[mplm_pkg::THR_T_W-1:0];
        mplm_pkg::REG_CURRENT_SQ_THR:   cfg_nxt.current_sq_threshold =
                                          pwdata[mplm_pkg::SQ_W-1:0];
        mplm_pkg::REG_LOSS_DURATION:    cfg_nxt.loss_duration = pwdata[mplm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_voltage          <= mplm_pkg::RST_MIN_VOLTAGE;
      cfg_r.low_speed_limit      <= mplm_pkg::RST_LOW_SPEED_LIMIT;
      cfg_r.rotating_speed       <= mplm_pkg::RST_ROTATING_SPEED;
      cfg_r.torque_threshold     <= mplm_pkg::RST_TORQUE_THRESHOLD;
      cfg_r.current_sq_threshold <= mplm_pkg::RST_CURRENT_SQ_THR;
      cfg_r.loss_duration        <= mplm_pkg::RST_LOSS_DURATION;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      mplm_pkg::REG_MIN_VOLTAGE:      prdata = {14'd0, cfg_r.min_voltage};
      mplm_pkg::REG_LOW_SPEED_LIMIT:  prdata = {8'd0, cfg_r.low_speed_limit};
      mplm_pkg::REG_ROTATING_SPEED:   prdata = {8'd0, cfg_r.rotating_speed};
      mplm_pkg::REG_TORQUE_THRESHOLD: prdata = {13'd0, cfg_r.torque_threshold};
      mplm_pkg::REG_CURRENT_SQ_THR:   prdata = cfg_r.current_sq_threshold;
      mplm_pkg::REG_LOSS_DURATION:    prdata = {16'd0, cfg_r.loss_duration};
      default:                        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/mplm_cond.sv */
// mplm_cond: threshold compares that decide how each loss counter moves
// depends on mplm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mplm_cond (
  input  wire mplm_pkg::cfg_t                     cfg,
  input  wire logic [mplm_pkg::VOLT_W-1:0]        voltage_amplitude,
  input  wire logic [mplm_pkg::SPEED_W-1:0]       speed_abs,
  input  wire logic signed [mplm_pkg::TORQ_W-1:0] torque_command,
  input  wire logic [mplm_pkg::SQ_W-1:0]          square_u,
  input  wire logic [mplm_pkg::SQ_W-1:0]          square_v,
  input  wire logic [mplm_pkg::SQ_W-1:0]          square_w,
  output      mplm_pkg::cnt_ctrl_t                sum_ctrl,
  output      mplm_pkg::cnt_ctrl_t                u_ctrl,
  output      mplm_pkg::cnt_ctrl_t                v_ctrl,
  output      mplm_pkg::cnt_ctrl_t                w_ctrl
);

  logic                               volt_ok;
  logic                               slow;
  logic                               rotating;
  logic                               torque_ok;
  logic                               phase_en;
  logic [mplm_pkg::SUM_W-1:0]         sq_sum;
  logic signed [mplm_pkg::TORQ_W-1:0] torque_thr_s;

  // detection enables
  assign volt_ok      = voltage_amplitude > cfg.min_voltage;
  assign slow         = speed_abs < cfg.low_speed_limit;
  assign rotating     = speed_abs >= cfg.rotating_speed;
  assign torque_thr_s = $signed({1'b0, cfg.torque_threshold});
  assign torque_ok    = torque_command > torque_thr_s;
  assign phase_en     = volt_ok && rotating && torque_ok;

  // full width sum of the three squares
  assign sq_sum = {2'b00, square_u} + {2'b00, square_v} + {2'b00, square_w};

  // shared counter, when voltage is ok: up on low summed current at low speed, else down
  assign sum_ctrl.upd      = volt_ok;
  assign sum_ctrl.up       = slow && (sq_sum < {2'b00, cfg.current_sq_threshold});
  assign sum_ctrl.clr_down = 1'b0;

  // phase counters, when voltage, speed and torque enable: up on low phase current, else cleared
  assign u_ctrl.upd      = phase_en;
  assign u_ctrl.up       = square_u < cfg.current_sq_threshold;
  assign u_ctrl.clr_down = 1'b1;
  assign v_ctrl.upd      = phase_en;
  assign v_ctrl.up       = square_v < cfg.current_sq_threshold;
  assign v_ctrl.clr_down = 1'b1;
  assign w_ctrl.upd      = phase_en;
  assign w_ctrl.up       = square_w < cfg.current_sq_threshold;
  assign w_ctrl.clr_down = 1'b1;

endmodule

`default_nettype wire

/* sv/mplm_loss_cnt.sv */
// mplm_loss_cnt: one saturating loss counter with duration clamp and trip
// depends on mplm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mplm_loss_cnt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire mplm_pkg::cnt_ctrl_t        ctrl,
  input  wire logic [mplm_pkg::CNT_W-1:0] duration,
  output      logic                       trip
);

  logic [mplm_pkg::CNT_W-1:0] cnt_r;
  logic [mplm_pkg::CNT_W-1:0] cnt_nxt;
  logic [mplm_pkg::CNT_W-1:0] cnt_upd;

  // count step
  always_comb begin
    cnt_upd = cnt_r;
    if (ctrl.upd) begin
      if (ctrl.up) begin
        cnt_upd = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
      end else if (ctrl.clr_down) begin
        cnt_upd = '0;
      end else if (cnt_r != '0) begin
        cnt_upd = cnt_r - 1'b1;
      end
    end
  end

  // clamp at duration
  assign trip    = cnt_upd > duration;
  assign cnt_nxt = trip ? duration : cnt_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv) begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (cnt_r <= $past(duration)))
    else $error("loss counter above duration after update");
`endif

endmodule

`default_nettype wire

/* verif/mplm_checker.sv */
// mplm_checker: watches the request, result and configuration ports of the monitor,
// predicts every tick result and compares it; depends on mplm_pkg only
`timescale 1ns / 1ps

module mplm_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [mplm_pkg::VOLT_W-1:0]        in_voltage_amplitude,
  input  wire logic [mplm_pkg::SPEED_W-1:0]       in_speed_abs,
  input  wire logic signed [mplm_pkg::TORQ_W-1:0] in_torque_command,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_u,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_v,
  input  wire logic [mplm_pkg::SQ_W-1:0]          in_square_w,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic                               out_error_flag,
  input  wire logic                               out_sum_trip,
  input  wire logic                               out_u_trip,
  input  wire logic                               out_v_trip,
  input  wire logic                               out_w_trip,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic                               pready,
  input  wire logic [mplm_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [mplm_pkg::DATA_W-1:0]        pwdata,
  output int                                      mismatches,
  output int                                      outstanding
);

  typedef struct packed {
    logic [mplm_pkg::VOLT_W-1:0]        volt;
    logic [mplm_pkg::SPEED_W-1:0]       speed;
    logic signed [mplm_pkg::TORQ_W-1:0] torque;
    logic [mplm_pkg::SQ_W-1:0]          sq_u;
    logic [mplm_pkg::SQ_W-1:0]          sq_v;
    logic [mplm_pkg::SQ_W-1:0]          sq_w;
  } tick_t;

  typedef struct packed {
    logic error_flag;
    logic sum_trip;
    logic u_trip;
    logic v_trip;
    logic w_trip;
  } trip_set_t;

  // own copy of the thresholds and of the loss counters (0 shared, 1..3 phases u, v, w)
  mplm_pkg::cfg_t             thresholds;
  logic [mplm_pkg::CNT_W-1:0] loss_cnt [4];
  logic                       sticky_err;

  trip_set_t expected_trips [$];
  trip_set_t want;
  trip_set_t got;
  int        fail_cnt = 0;
  int        result_idx = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [mplm_pkg::CNT_W-1:0] bump(logic [mplm_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // clamp a counter that passed the duration and latch the sticky error
  function automatic logic clamp_count(int i);
    if (loss_cnt[i] > thresholds.loss_duration) begin
      loss_cnt[i] = thresholds.loss_duration;
      sticky_err  = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one tick of the monitor: counter update, then trip check
  function automatic trip_set_t step_monitor(tick_t t);
    logic [mplm_pkg::SUM_W-1:0] total;
    logic [mplm_pkg::SUM_W-1:0] limit;
    logic                       spin;
    trip_set_t                  r;
    total = {2'b00, t.sq_u} + {2'b00, t.sq_v} + {2'b00, t.sq_w};
    limit = {2'b00, thresholds.current_sq_threshold};
    if (t.volt > thresholds.min_voltage) begin
      if (t.speed < thresholds.low_speed_limit && total < limit) begin
        loss_cnt[0] = bump(loss_cnt[0]);
      end else if (loss_cnt[0] != '0) begin
        loss_cnt[0] = loss_cnt[0] - 1'b1;
      end
      spin = (t.speed >= thresholds.rotating_speed) &&
             ($signed(t.torque) > $signed({1'b0, thresholds.torque_threshold}));
      if (spin) begin
        loss_cnt[1] = (t.sq_u < thresholds.current_sq_threshold) ? bump(loss_cnt[1]) : '0;
        loss_cnt[2] = (t.sq_v < thresholds.current_sq_threshold) ? bump(loss_cnt[2]) : '0;
        loss_cnt[3] = (t.sq_w < thresholds.current_sq_threshold) ? bump(loss_cnt[3]) : '0;
      end
    end
    r.sum_trip   = clamp_count(0);
    r.u_trip     = clamp_count(1);
    r.v_trip     = clamp_count(2);
    r.w_trip     = clamp_count(3);
    r.error_flag = sticky_err;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thresholds.min_voltage          = mplm_pkg::RST_MIN_VOLTAGE;
      thresholds.low_speed_limit      = mplm_pkg::RST_LOW_SPEED_LIMIT;
      thresholds.rotating_speed       = mplm_pkg::RST_ROTATING_SPEED;
      thresholds.torque_threshold     = mplm_pkg::RST_TORQUE_THRESHOLD;
      thresholds.current_sq_threshold = mplm_pkg::RST_CURRENT_SQ_THR;
      thresholds.loss_duration        = mplm_pkg::RST_LOSS_DURATION;
      for (int i = 0; i < 4; i++) loss_cnt[i] = '0;
      sticky_err = 1'b0;
      expected_trips.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (mplm_pkg::reg_idx_t'(paddr[mplm_pkg::ADDR_W-1:2]))
          mplm_pkg::REG_MIN_VOLTAGE:
            thresholds.min_voltage = pwdata[mplm_pkg::VOLT_W-1:0];
          mplm_pkg::REG_LOW_SPEED_LIMIT:
            thresholds.low_speed_limit = pwdata[mplm_pkg::SPEED_W-1:0];
          mplm_pkg::REG_ROTATING_SPEED:
            thresholds.rotating_speed = pwdata[mplm_pkg::SPEED_W-1:0];
          mplm_pkg::REG_TORQUE_THRESHOLD:
            thresholds.torque_threshold = pwdata[mplm_pkg::THR_T_W-1:0];
          mplm_pkg::REG_CURRENT_SQ_THR:
            thresholds.current_sq_threshold = pwdata[mplm_pkg::SQ_W-1:0];
          mplm_pkg::REG_LOSS_DURATION:
            thresholds.loss_duration = pwdata[mplm_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // result compare against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_error_flag, out_sum_trip, out_u_trip, out_v_trip, out_w_trip};
        if (expected_trips.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d with no request pending: err=%b sum=%b u=%b v=%b w=%b",
                     result_idx, got.error_flag, got.sum_trip, got.u_trip, got.v_trip,
                     got.w_trip);
        end else begin
          want = expected_trips.pop_front();
          if (got.error_flag !== want.error_flag || got.sum_trip !== want.sum_trip ||
              got.u_trip !== want.u_trip || got.v_trip !== want.v_trip ||
              got.w_trip !== want.w_trip) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("result %0d mismatch: exp err=%b sum=%b u=%b v=%b w=%b",
                       result_idx, want.error_flag, want.sum_trip, want.u_trip,
                       want.v_trip, want.w_trip);
              $display("result %0d mismatch: got err=%b sum=%b u=%b v=%b w=%b",
                       result_idx, got.error_flag, got.sum_trip, got.u_trip,
                       got.v_trip, got.w_trip);
            end
          end
        end
        result_idx++;
      end

      // accepted request: predict its result
      if (in_valid && in_ready)
        expected_trips.push_back(step_monitor('{in_voltage_amplitude, in_speed_abs,
                                                in_torque_command, in_square_u,
                                                in_square_v, in_square_w}));
    end
    mismatches  <= fail_cnt;
    outstanding <= expected_trips.size();
  end

endmodule

/* verif/tb.sv */
// tb: stimulus and verdict for motor_phase_loss_monitor; directed ticks, counter
// run-up with a lowered duration, then random phases over several threshold settings
// depends on mplm_pkg, motor_phase_loss_monitor and mplm_checker
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 150;
  localparam int RUN_UP_TICKS = 30;

  typedef struct packed {
    logic [mplm_pkg::VOLT_W-1:0]        volt;
    logic [mplm_pkg::SPEED_W-1:0]       speed;
    logic signed [mplm_pkg::TORQ_W-1:0] torque;
    logic [mplm_pkg::SQ_W-1:0]          sq_u;
    logic [mplm_pkg::SQ_W-1:0]          sq_v;
    logic [mplm_pkg::SQ_W-1:0]          sq_w;
  } tick_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [mplm_pkg::VOLT_W-1:0]         in_voltage_amplitude = '0;
  logic [mplm_pkg::SPEED_W-1:0]        in_speed_abs = '0;
  logic signed [mplm_pkg::TORQ_W-1:0]  in_torque_command = '0;
  logic [mplm_pkg::SQ_W-1:0]           in_square_u = '0;
  logic [mplm_pkg::SQ_W-1:0]           in_square_v = '0;
  logic [mplm_pkg::SQ_W-1:0]           in_square_w = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                out_error_flag;
  logic                                out_sum_trip;
  logic                                out_u_trip;
  logic                                out_v_trip;
  logic                                out_w_trip;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [mplm_pkg::ADDR_W-1:0]         paddr = '0;
  logic [mplm_pkg::DATA_W-1:0]         pwdata = '0;
  logic [mplm_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   idle_pct = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  motor_phase_loss_monitor dut (.*);

  mplm_checker loss_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_voltage_amplitude, .in_speed_abs, .in_torque_command,
    .in_square_u, .in_square_v, .in_square_w,
    .out_valid, .out_ready, .out_error_flag, .out_sum_trip, .out_u_trip, .out_v_trip,
    .out_w_trip,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .outstanding
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result side: random ready bursts, one long hold on demand, none when quiet
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk);
        if (!quiet) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(9, 1)) @(posedge clk);
        end
      end
    end
  end

  function automatic tick_t mk_tick(int unsigned v, int unsigned s, int t,
                                    int unsigned u, int unsigned vv, int unsigned w);
    tick_t r;
    r.volt   = v[mplm_pkg::VOLT_W-1:0];
    r.speed  = s[mplm_pkg::SPEED_W-1:0];
    r.torque = t[mplm_pkg::TORQ_W-1:0];
    r.sq_u   = u;
    r.sq_v   = vv;
    r.sq_w   = w;
    return r;
  endfunction

  function automatic logic [31:0] below(logic [31:0] x);
    return (x == 0) ? 32'd0 : $urandom_range(x - 1, 0);
  endfunction

  function automatic logic [31:0] above(logic [31:0] x, logic [31:0] top);
    return (x >= top) ? top : $urandom_range(top, x + 1);
  endfunction

  function automatic tick_t noise_tick();
    return mk_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // tick shaped to drive the counters: loss[0] asks for a low sum, loss[3:1] per phase
  function automatic tick_t shaped_tick(mplm_pkg::cfg_t c, logic [3:0] loss, logic spin);
    tick_t       t;
    logic [31:0] thr;
    logic [31:0] r32;
    thr    = c.current_sq_threshold;
    r32    = above(32'(c.min_voltage), 32'h3FFFF);
    t.volt = r32[mplm_pkg::VOLT_W-1:0];
    if (spin) begin
      if (c.rotating_speed < c.low_speed_limit && $urandom_range(1, 0))
        r32 = $urandom_range(32'(c.low_speed_limit) - 32'd1, 32'(c.rotating_speed));
      else
        r32 = $urandom_range(32'hFF_FFFF, 32'(c.rotating_speed));
      t.speed  = r32[mplm_pkg::SPEED_W-1:0];
      r32      = above(32'(c.torque_threshold), 32'h7FFFF);
      t.torque = r32[mplm_pkg::TORQ_W-1:0];
    end else begin
      r32      = below(32'(c.low_speed_limit));
      t.speed  = r32[mplm_pkg::SPEED_W-1:0];
      r32      = $urandom;
      t.torque = r32[mplm_pkg::TORQ_W-1:0];
    end
    if (loss[0]) begin
      t.sq_u = below(thr / 3);
      t.sq_v = below(thr / 3);
      t.sq_w = below(thr / 3);
    end else begin
      t.sq_u = loss[1] ? below(thr) : $urandom_range(32'hFFFF_FFFF, thr);
      t.sq_v = loss[2] ? below(thr) : $urandom_range(32'hFFFF_FFFF, thr);
      t.sq_w = loss[3] ? below(thr) : $urandom_range(32'hFFFF_FFFF, thr);
    end
    return t;
  endfunction

  function automatic mplm_pkg::cfg_t rand_settings();
    mplm_pkg::cfg_t c;
    logic [31:0]    r32;
    r32                    = $urandom_range(3000, 0);
    c.min_voltage          = r32[mplm_pkg::VOLT_W-1:0];
    r32                    = $urandom_range(40000, 1);
    c.low_speed_limit      = r32[mplm_pkg::SPEED_W-1:0];
    r32                    = $urandom_range(30000, 0);
    c.rotating_speed       = r32[mplm_pkg::SPEED_W-1:0];
    r32                    = $urandom_range(2000, 0);
    c.torque_threshold     = r32[mplm_pkg::THR_T_W-1:0];
    c.current_sq_threshold = $urandom_range(3, 0) ? $urandom_range(100000, 3) : $urandom;
    r32                    = $urandom_range(12, 1);
    c.loss_duration        = r32[mplm_pkg::CNT_W-1:0];
    return c;
  endfunction

  task automatic write_reg(mplm_pkg::reg_idx_t idx, logic [mplm_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(mplm_pkg::cfg_t c);
    write_reg(mplm_pkg::REG_MIN_VOLTAGE, 32'(c.min_voltage));
    write_reg(mplm_pkg::REG_LOW_SPEED_LIMIT, 32'(c.low_speed_limit));
    write_reg(mplm_pkg::REG_ROTATING_SPEED, 32'(c.rotating_speed));
    write_reg(mplm_pkg::REG_TORQUE_THRESHOLD, 32'(c.torque_threshold));
    write_reg(mplm_pkg::REG_CURRENT_SQ_THR, c.current_sq_threshold);
    write_reg(mplm_pkg::REG_LOSS_DURATION, 32'(c.loss_duration));
  endtask

  // offer one request, with an optional idle burst first, and wait for its accept
  task automatic send_tick(tick_t t);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
    in_voltage_amplitude <= t.volt;
    in_speed_abs         <= t.speed;
    in_torque_command    <= t.torque;
    in_square_u          <= t.sq_u;
    in_square_v          <= t.sq_v;
    in_square_w          <= t.sq_w;
    in_valid             <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // random streaks of shaped ticks under one setting, with some noise streaks
  task automatic run_phase(mplm_pkg::cfg_t c, int n_ticks);
    int          sent;
    int          streak;
    int          cap;
    logic        noisy;
    logic [3:0]  loss;
    logic        spin;
    logic [31:0] r32;
    apply_settings(c);
    idle_pct = quiet ? 0 : $urandom_range(40, 0);
    sent = 0;
    cap = (c.loss_duration > 36) ? 40 : c.loss_duration + 4;
    while (sent < n_ticks) begin
      streak = $urandom_range(cap, 1);
      noisy  = ($urandom_range(4, 0) == 0);
      r32    = $urandom_range(15, 0);
      loss   = r32[3:0];
      r32    = $urandom_range(1, 0);
      spin   = r32[0];
      for (int k = 0; k < streak && sent < n_ticks; k++) begin
        send_tick(noisy ? noise_tick() : shaped_tick(c, loss, spin));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    mplm_pkg::cfg_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: field extremes and the boundaries of the enable and sum compares
    idle_pct = 30;
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(32'h3FFFF, 0, 524287, 0, 0, 0));
    send_tick(mk_tick(32'h3FFFF, 32'hFFFFFF, -524288, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF));
    send_tick(mk_tick(173, 10723, 18, 0, 32'hFFFF_FFFF, 206));
    send_tick(mk_tick(172, 100, 100, 0, 0, 0));
    send_tick(mk_tick(200, 25599, 17, 69, 69, 68));
    send_tick(mk_tick(200, 25600, -1, 0, 0, 0));
    send_tick(mk_tick(200, 10722, 500, 0, 0, 0));
    send_tick(mk_tick(200, 12000, 500, 69, 69, 69));
    drain();

    // short duration: phase trips, shared trip, torque gate, speed gate, voltage gate
    apply_settings('{18'd0, 24'd1000, 24'd500, 19'd0, 32'd100, 16'd2});
    for (int i = 0; i < 3; i++) send_tick(mk_tick(1, 600, 1, 0, 0, 200));
    for (int i = 0; i < 3; i++) send_tick(mk_tick(1, 600, 1, 200, 200, 0));
    for (int i = 0; i < 3; i++) send_tick(mk_tick(1, 600, 1, 10, 10, 10));
    send_tick(mk_tick(1, 600, -5, 0, 0, 0));
    send_tick(mk_tick(1, 2000, 1, 10, 10, 10));
    send_tick(mk_tick(0, 600, 1, 0, 0, 0));
    drain();

    // zero duration clamps every nonzero counter
    write_reg(mplm_pkg::REG_LOSS_DURATION, 0);
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    drain();

    // all counters run up under an unreachable duration
    quiet = 1'b1;
    idle_pct = 0;
    apply_settings('{18'd0, 24'hFFFFFF, 24'd0, 19'd0, 32'hFFFF_FFFF, 16'hFFFF});
    for (int i = 0; i < RUN_UP_TICKS; i++) send_tick(mk_tick(32'h3FFFF, 0, 1, 0, 0, 0));
    drain();
    // lowered duration trips at once, voltage low
    write_reg(mplm_pkg::REG_LOSS_DURATION, 10);
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 0, 0));
    drain();
    quiet = 1'b0;

    // random phases over extreme and random settings
    run_phase('{18'd0, 24'hFFFFFF, 24'd0, 19'd0, 32'hFFFF_FFFF, 16'd1}, 60);
    run_phase('{18'h3FFFF, 24'd0, 24'hFFFFFF, 19'h7FFFF, 32'd0, 16'd65534}, 40);
    c = '{mplm_pkg::RST_MIN_VOLTAGE, mplm_pkg::RST_LOW_SPEED_LIMIT,
          mplm_pkg::RST_ROTATING_SPEED, mplm_pkg::RST_TORQUE_THRESHOLD,
          mplm_pkg::RST_CURRENT_SQ_THR, 16'd5};
    run_phase(c, 60);
    hold_req = 1'b1;
    run_phase(rand_settings(), 70);
    for (int p = 0; p < 3; p++) run_phase(rand_settings(), 60);
    quiet = 1'b1;
    run_phase(rand_settings(), 60);

    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
